### hdl/three_tap_echo_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-tap echo
// Shorthands for clocked properties that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_TAP_ECHO_ASSERT_SVH
`define THREE_TAP_ECHO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tte_pkg.sv
// ----------------------------------------------------------------------------
// Three-tap echo package
// Widths, register indexes, reset values and mixing constants.
// ----------------------------------------------------------------------------
package tte_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WEIGHT_W       = 15;
    localparam int DELAY_FRAMES_W = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 15;
    localparam int TAP_COUNT      = 3;

    localparam int FRAME_SAMPLES_DEF    = 1024;
    localparam int MAX_DELAY_FRAMES_DEF = 15;

    // The mix is clamped to a 30-bit signed range before the final shift.
    localparam int MIX_SHIFT = 14;
    localparam int CLAMP_W   = 30;
    localparam int SUM_HIGH  = 32'sh1fff_ffff;
    localparam int SUM_LOW   = -536870912;

    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic        [WEIGHT_W-1:0]   weight_t;
    typedef logic        [DELAY_FRAMES_W-1:0] frames_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ECHO_ENABLE,
        REG_DELAY_FRAMES,
        REG_TAP1_WEIGHT,
        REG_TAP2_WEIGHT,
        REG_TAP3_WEIGHT
    } cfg_reg_t;

    localparam frames_t DELAY_FRAMES_RST = frames_t'(5);
    localparam weight_t TAP1_WEIGHT_RST  = weight_t'(16383);
    localparam weight_t TAP2_WEIGHT_RST  = weight_t'(8191);
    localparam weight_t TAP3_WEIGHT_RST  = weight_t'(4095);

endpackage

### hdl/tte_stream_if.sv
// ----------------------------------------------------------------------------
// Three-tap echo sample channels
// Valid/ready channels carrying one audio sample per transaction.
// ----------------------------------------------------------------------------
interface tte_in_if;
    import tte_pkg::*;

    logic    valid;
    logic    ready;
    sample_t in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface tte_out_if;
    import tte_pkg::*;

    logic    valid;
    logic    ready;
    sample_t out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

### hdl/three_tap_echo.sv
// ----------------------------------------------------------------------------
// Three-tap echo
// Mixes three delayed, weighted copies of a sample stream into the stream when echo is enabled.
// ----------------------------------------------------------------------------
// Samples arrive on the samples channel and leave on the echoed channel, one
// result per transaction, in order. Both are valid/ready channels. Registers
// are written through cfg_write, cfg_index and cfg_data; the user must write
// them only while the block is idle; the block does not enforce this.
// Writing the delay empties the delay line. One sample can be taken every
// cycle unless the receiver stalls. The rate is set by the delay line: each
// tap has its own copy of the store with one write and one read port, so the
// three tap reads and the write of a sample share a single cycle. Slots not
// yet written since the last clear read as zero: the write pointer and a
// wrap flag act as a fill count, so no clearing pass is needed. Reset loads
// the register defaults, rewinds the write pointer and empties the pipeline.
// When the receiver stalls, the pipeline closes up its bubbles and then
// holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module three_tap_echo #(
    parameter int FRAME_SAMPLES    = tte_pkg::FRAME_SAMPLES_DEF,
    parameter int MAX_DELAY_FRAMES = tte_pkg::MAX_DELAY_FRAMES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_data,
    tte_in_if.sink                         samples,
    tte_out_if.source                      echoed
);
    import tte_pkg::*;

    localparam int STORE_LEN = MAX_DELAY_FRAMES * TAP_COUNT * FRAME_SAMPLES;
    localparam int AW        = $clog2(STORE_LEN);
    localparam int DW        = $clog2(STORE_LEN + 1);
    localparam int FW        = $clog2(MAX_DELAY_FRAMES + 1);
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W     = PROD_W + 2;

    // Configuration and write pointer.
    logic                 echo_enable_reg;
    frames_t              delay_frames_reg;
    weight_t              weight_reg [TAP_COUNT];
    logic [AW-1:0]        wp_reg;
    logic [AW-1:0]        wp_next;
    logic                 wrapped_reg;
    logic [FW-1:0]        frames;

    // Handshake and stage enables.
    logic                 en1, en2, en3, en4;
    logic                 accept;
    logic                 store_wr;

    // Stage 1: sample and raw tap reads.
    logic                 v1_reg;
    sample_t              x1_reg;
    logic                 echo1_reg;
    logic                 zero1_reg;
    logic [TAP_COUNT-1:0] live1_reg;
    logic [TAP_COUNT-1:0] tap_live;
    logic [SAMPLE_W-1:0]  tap_rd [TAP_COUNT];

    // Stage 2: weighted taps.
    logic                     v2_reg;
    sample_t                  x2_reg;
    logic                     echo2_reg;
    logic signed [PROD_W-1:0] prod2_reg [TAP_COUNT];
    logic signed [PROD_W-1:0] prod    [TAP_COUNT];

    // Stage 3: tap sum.
    logic                    v3_reg;
    sample_t                 x3_reg;
    logic                    echo3_reg;
    logic signed [ACC_W-1:0] acc3_reg;
    logic signed [ACC_W-1:0] acc_next;

    // Stage 4: output register.
    logic                      out_valid_reg;
    sample_t                   out_sample_reg;
    sample_t                   out_sample_next;
    logic signed [ACC_W-1:0]   mix;
    logic signed [CLAMP_W-1:0] clamped;

    always_comb
    begin
        if (int'(delay_frames_reg) > MAX_DELAY_FRAMES)
        begin
            frames = FW'(MAX_DELAY_FRAMES);
        end
        else
        begin
            frames = FW'(delay_frames_reg);
        end
    end

    assign wp_next = (wp_reg == AW'(STORE_LEN - 1)) ? '0 : wp_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg  <= 1'b0;
            delay_frames_reg <= DELAY_FRAMES_RST;
            weight_reg[0]    <= TAP1_WEIGHT_RST;
            weight_reg[1]    <= TAP2_WEIGHT_RST;
            weight_reg[2]    <= TAP3_WEIGHT_RST;
            wp_reg           <= '0;
            wrapped_reg      <= 1'b0;
        end
        else
        begin
            if (store_wr)
            begin
                wp_reg <= wp_next;
                if (wp_reg == AW'(STORE_LEN - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ECHO_ENABLE:  echo_enable_reg <= cfg_data[0];
                    REG_DELAY_FRAMES:
                    begin
                        delay_frames_reg <= cfg_data[DELAY_FRAMES_W-1:0];
                        wp_reg           <= '0;
                        wrapped_reg      <= 1'b0;
                    end
                    REG_TAP1_WEIGHT:  weight_reg[0] <= cfg_data[WEIGHT_W-1:0];
                    REG_TAP2_WEIGHT:  weight_reg[1] <= cfg_data[WEIGHT_W-1:0];
                    REG_TAP3_WEIGHT:  weight_reg[2] <= cfg_data[WEIGHT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Each stage moves when it is empty or the stage after it moves.
    assign en4 = !out_valid_reg || echoed.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign samples.ready = en1;
    assign accept        = samples.valid && en1;
    assign store_wr      = accept && echo_enable_reg;

    // One copy of the delay line per tap. A tap that reaches back the whole
    // length reads the slot that is being overwritten, and gets the old data.
    for (genvar k = 0; k < TAP_COUNT; k++)
    begin : g_tap
        logic [DW-1:0]       tap_span;
        logic [DW:0]         addr_sum;
        logic [AW-1:0]       raddr;
        logic [SAMPLE_W-1:0] store_mem [STORE_LEN];
        logic [SAMPLE_W-1:0] rd_reg;

        assign tap_span = DW'(frames) * DW'((k + 1) * FRAME_SAMPLES);
        assign addr_sum = (DW+1)'(wp_reg) + (DW+1)'(STORE_LEN) - (DW+1)'(tap_span);
        assign raddr    = (addr_sum >= (DW+1)'(STORE_LEN))
                          ? AW'(addr_sum - (DW+1)'(STORE_LEN)) : AW'(addr_sum);
        assign tap_live[k] = wrapped_reg || (DW'(wp_reg) >= tap_span);
        assign tap_rd[k]   = rd_reg;

        always_ff @(posedge clk)
        begin
            if (store_wr)
            begin
                store_mem[wp_reg] <= samples.in_sample;
            end
            if (accept)
            begin
                rd_reg <= store_mem[raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= samples.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Weighting: a slot never written reads as zero, a zero delay reads the
    // current sample.
    always_comb
    begin
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            logic signed [PROD_W-1:0] tap_ext;
            logic signed [PROD_W-1:0] weight_ext;
            sample_t                  tap_val;

            if (zero1_reg)
            begin
                tap_val = x1_reg;
            end
            else if (live1_reg[k])
            begin
                tap_val = sample_t'(tap_rd[k]);
            end
            else
            begin
                tap_val = '0;
            end
            tap_ext    = PROD_W'(tap_val);
            weight_ext = signed'(PROD_W'(weight_reg[k]));
            prod[k]    = tap_ext * weight_ext;
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            acc_next = acc_next + ACC_W'(prod2_reg[k]);
        end
    end

    always_comb
    begin
        mix = (acc3_reg >>> 1) + (ACC_W'(x3_reg) <<< MIX_SHIFT);
        if (mix > ACC_W'(SUM_HIGH))
        begin
            clamped = CLAMP_W'(SUM_HIGH);
        end
        else if (mix < ACC_W'(SUM_LOW))
        begin
            clamped = CLAMP_W'(SUM_LOW);
        end
        else
        begin
            clamped = CLAMP_W'(mix);
        end
        if (echo3_reg)
        begin
            out_sample_next = SAMPLE_W'(clamped >>> MIX_SHIFT);
        end
        else
        begin
            out_sample_next = x3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg    <= samples.in_sample;
            echo1_reg <= echo_enable_reg;
            zero1_reg <= (frames == '0);
            live1_reg <= tap_live;
        end
        if (en2)
        begin
            x2_reg    <= x1_reg;
            echo2_reg <= echo1_reg;
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                prod2_reg[k] <= prod[k];
            end
        end
        if (en3)
        begin
            x3_reg    <= x2_reg;
            echo3_reg <= echo2_reg;
            acc3_reg  <= acc_next;
        end
        if (en4)
        begin
            out_sample_reg <= out_sample_next;
        end
    end

    assign echoed.valid      = out_valid_reg;
    assign echoed.out_sample = out_sample_reg;

endmodule

### hdl/tte_checker.sv
// ----------------------------------------------------------------------------
// Three-tap echo port checker
// Watches the sample channels of the top level for flow-control faults.
// ----------------------------------------------------------------------------
`include "three_tap_echo_assert.svh"

module tte_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input tte_pkg::sample_t out_sample
);
    import tte_pkg::*;

    // A result that is not taken stays on the port unchanged.
    `TTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample), "stalled result changed")

    // With nothing waiting at the output, the pipeline can always take a sample.
    `TTE_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input blocked with empty output")

    // Without back-pressure, an accepted sample passes the stage registers and is presented at the output.
    `TTE_ASSERT_NEXT(a_latency, in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result missing after four cycles")

endmodule

bind three_tap_echo tte_checker u_tte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (echoed.valid),
    .out_ready  (echoed.ready),
    .out_sample (echoed.out_sample)
);
